// ===== src/sset_pkg.sv =====
package sset_pkg;

  // Widths of the request and result fields.
  localparam int KIND_W   = 3;
  localparam int ENT_W    = 10;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Number of distinct identifiers that the entity field can name.
  localparam int ENTITY_SPACE = 1 << ENT_W;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // write one zero into the position map
    logic accept;  // take a request, start the map and list reads
    logic fetch;   // capture the first reads, read the list at the mapped slot
    logic exec;    // decide, write back, load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at its last entry
    logic out_free;  // the result register can be loaded this cycle
  } dp_sts_t;

endpackage

// ===== src/sset_ctrl.sv =====
module sset_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sset_pkg::dp_sts_t sts,
  output sset_pkg::ctl_cmd_t cmd
);
  import sset_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // An accepted request always moves on to the fetch step.
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_FETCH))
    else $error("accepted request did not enter fetch");

  // The fetch step always leads straight into execute.
  a_fetch_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r == S_EXEC))
    else $error("fetch did not lead to execute");

  // A blocked result register keeps the operation waiting in execute.
  a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !sts.out_free) |=> (state_r == S_EXEC))
    else $error("execute left while result register was busy");

endmodule

// ===== src/sset_dp.sv =====
module sset_dp #(
  parameter int MAX_ENTITIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sset_pkg::ctl_cmd_t               cmd,
  output sset_pkg::dp_sts_t                sts,
  input  logic [sset_pkg::KIND_W-1:0]      in_kind,
  input  logic [sset_pkg::ENT_W-1:0]       in_entity,
  input  logic [sset_pkg::POS_W-1:0]       in_position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sset_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_found,
  output logic [sset_pkg::POS_W-1:0]       out_index,
  output logic [sset_pkg::ENT_W-1:0]       out_entity_out,
  output logic [sset_pkg::COUNT_W-1:0]     out_count
);
  import sset_pkg::*;

  // Only identifiers the entity field can name ever become members.
  localparam int CAP = (MAX_ENTITIES < ENTITY_SPACE) ? MAX_ENTITIES : ENTITY_SPACE;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = $clog2(CAP + 1);
  localparam logic [ENT_W:0]     CAP_E = (ENT_W + 1)'(CAP);
  localparam logic [CW-1:0]      CAP_C = CW'(CAP);
  localparam logic [AW-1:0]      LAST_A = AW'(CAP - 1);

  logic [AW-1:0] map_mem_r  [CAP];
  logic [AW-1:0] list_mem_r [CAP];
  logic [AW-1:0] map_q_r;
  logic [AW-1:0] list_q_r;

  logic [KIND_W-1:0] kind_r;
  logic [ENT_W-1:0]  ent_r;
  logic [POS_W-1:0]  pos_r;
  logic [AW-1:0]     p_r;
  logic [AW-1:0]     aux_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [CW-1:0]     cnt_dec;
  logic [AW-1:0]     clr_cnt_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic                found_r;
  logic [AW-1:0]       index_r;
  logic [AW-1:0]       eout_r;
  logic [CW-1:0]       count_r;

  logic                ent_ok;
  logic                member;
  logic [STATUS_W-1:0] status_nxt;
  logic [AW-1:0]       idx_nxt;
  logic [AW-1:0]       eout_nxt;
  logic                map_we;
  logic [AW-1:0]       map_wa;
  logic [AW-1:0]       map_wd;
  logic                list_we;
  logic [AW-1:0]       list_wa;
  logic [AW-1:0]       list_wd;
  logic [AW-1:0]       list_ra;

  assign cnt_dec = cnt_r - CW'(1);
  assign ent_ok  = ({1'b0, ent_r} < CAP_E);

  assign sts.clr_last = (clr_cnt_r == LAST_A);
  assign sts.out_free = !out_valid_r || out_ready;

  // The list is read at the requested position or the last member when a
  // request arrives, then at the slot the map points to.
  always_comb begin
    if (cmd.fetch) begin
      list_ra = map_q_r;
    end else if (in_kind == KIND_READ) begin
      list_ra = in_position[AW-1:0];
    end else begin
      list_ra = cnt_dec[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem_r[map_wa] <= map_wd;
    if (cmd.accept) map_q_r <= map_mem_r[in_entity[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem_r[list_wa] <= list_wd;
    if (cmd.accept || cmd.fetch) list_q_r <= list_mem_r[list_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      ent_r  <= in_entity;
      pos_r  <= in_position;
    end
    if (cmd.fetch) begin
      p_r   <= map_q_r;
      aux_r <= list_q_r;
    end
  end

  always_comb begin
    member     = ent_ok && (CW'(p_r) < cnt_r) && (list_q_r == ent_r[AW-1:0]);
    status_nxt = ST_OK;
    idx_nxt    = '0;
    eout_nxt   = '0;
    cnt_nxt    = cnt_r;
    map_we     = cmd.clr;
    map_wa     = clr_cnt_r;
    map_wd     = '0;
    list_we    = 1'b0;
    list_wa    = p_r;
    list_wd    = aux_r;
    unique case (kind_r)
      KIND_INSERT: begin
        if (member) begin
          status_nxt = ST_PRESENT;
        end else if (!ent_ok || cnt_r == CAP_C) begin
          status_nxt = ST_RANGE;
        end else begin
          list_we = cmd.exec;
          list_wa = cnt_r[AW-1:0];
          list_wd = ent_r[AW-1:0];
          map_we  = cmd.exec;
          map_wa  = ent_r[AW-1:0];
          map_wd  = cnt_r[AW-1:0];
          idx_nxt = cnt_r[AW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (!member) begin
          status_nxt = ST_ABSENT;
        end else begin
          // The last member fills the hole and its map entry follows it.
          list_we = cmd.exec;
          list_wa = p_r;
          list_wd = aux_r;
          map_we  = cmd.exec;
          map_wa  = aux_r;
          map_wd  = p_r;
          idx_nxt = p_r;
          cnt_nxt = cnt_dec;
        end
      end
      KIND_LOOKUP: begin
        if (!member) begin
          status_nxt = ST_ABSENT;
        end else begin
          idx_nxt = p_r;
        end
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      KIND_READ: begin
        if ((COUNT_W)'(pos_r) < (COUNT_W)'(cnt_r)) begin
          eout_nxt = aux_r;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    // The clearing pass owns the map write port whatever request was last held.
    if (cmd.clr) begin
      map_we = 1'b1;
      map_wa = clr_cnt_r;
      map_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.exec) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      found_r  <= member;
      index_r  <= idx_nxt;
      eout_r   <= eout_nxt;
      count_r  <= cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_found      = found_r;
  assign out_index      = POS_W'(index_r);
  assign out_entity_out = ENT_W'(eout_r);
  assign out_count      = COUNT_W'(count_r);

  // The member count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CAP_C))
    else $error("member count above capacity");

  // A result is only loaded over a register that is empty or being drained.
  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // Every executed operation presents a result in the next cycle.
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed operation produced no result");

endmodule

// ===== src/sparse_set_membership_table.sv =====
// Flow: a request is taken in the idle state, the mapped slot is read in the fetch state,
// and the result is registered as the execute state ends; it then shows on out_.
// Requests do not overlap, as the map-then-list reads are dependent and each memory
// has a single read port; a stalled result holds the next request in execute.
// Reset: synchronous, active low. The position map is then swept to zero, one entry
// a cycle, over its min(MAX_ENTITIES, 1024) entries, during which in_ready stays low.
module sparse_set_membership_table #(
  parameter int MAX_ENTITIES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sset_pkg::KIND_W-1:0]   in_kind,
  input  logic [sset_pkg::ENT_W-1:0]    in_entity,
  input  logic [sset_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sset_pkg::STATUS_W-1:0] out_status,
  output logic                          out_found,
  output logic [sset_pkg::POS_W-1:0]    out_index,
  output logic [sset_pkg::ENT_W-1:0]    out_entity_out,
  output logic [sset_pkg::COUNT_W-1:0]  out_count
);
  import sset_pkg::*;

  // The set is kept as two memories. The packed list holds the members
  // back to back in positions below the count; the position map tells, for
  // every identifier, where in the packed list it was last placed. An
  // identifier is a member when its map entry is below the count and the
  // list holds that same identifier there, so stale map entries left behind
  // by remove or clear are harmless and clear only has to zero the count.
  //
  // The controller walks each request through three steps:
  //   accept  - latch the request, read the map at the identifier and the
  //             list at either the requested position (read) or the last
  //             member (needed by remove);
  //   fetch   - read the list at the slot the map returned;
  //   execute - decide membership, write back at most one entry of each
  //             memory, and load the result register.
  // Remove moves the last member into the freed slot and points its map
  // entry there, which touches each memory once, so it fits the same step.
  //
  // The result register parts the two channels: a new request is accepted
  // while the previous result still waits, and only the execute step stalls
  // until that result is taken.

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  sset_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sset_dp #(
    .MAX_ENTITIES (MAX_ENTITIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_entity      (in_entity),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_index      (out_index),
    .out_entity_out (out_entity_out),
    .out_count      (out_count)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sset_pkg::*;

  // Capacity of the instance under test; the identifier space is exactly this large,
  // so a full set holds every identifier.
  localparam int SET_CAPACITY = 1024;

  // Spare operation codes that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  // The receiver holds off this long once, so that the block backs up into its input.
  localparam int HOLD_CYCLES = 300;

  // The clearing pass after reset runs with no request taken; the limit must outlast it.
  localparam int WATCHDOG_LIMIT = 5000;

  // Cycles allowed after the last expected result for stray results to show up.
  localparam int DRAIN_CYCLES = 20;

  localparam int RANDOM_MIX_ITEMS = 200;
  localparam int POOL_SIZE = 64;

  // Number of distinct identifiers inserted by the fill phase.
  localparam int FILL_ITEMS = 520;

  // One expected result, field by field.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    index;
    logic [ENT_W-1:0]    entity_out;
    logic [COUNT_W-1:0]  count;
  } set_result_t;

  // Keeps its own copy of the sparse set, works out the result of every accepted
  // request and checks the results of the block in order against those answers.
  class set_scoreboard;
    logic [POS_W-1:0] slot_of [SET_CAPACITY];
    logic [ENT_W-1:0] dense_ids [SET_CAPACITY];
    int unsigned      size;
    set_result_t      answers_q[$];
    int               errors;

    function new();
      foreach (slot_of[i]) begin
        slot_of[i]   = '0;
        dense_ids[i] = '0;
      end
      size   = 0;
      errors = 0;
    endfunction

    // An identifier is a member when its map entry points below the count at a
    // dense slot that holds that same identifier; stale entries fail one test or the other.
    function bit holds(logic [ENT_W-1:0] ent);
      int unsigned p;
      if (ent >= SET_CAPACITY) return 1'b0;
      p = 32'(slot_of[ent]);
      return (p < size) && (dense_ids[p] == ent);
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [ENT_W-1:0] ent,
                               logic [POS_W-1:0] pos);
      set_result_t      r;
      bit               was_member;
      int unsigned      hole;
      logic [ENT_W-1:0] last;
      was_member = holds(ent);
      r          = '0;
      r.found    = was_member;
      unique case (kind)
        KIND_INSERT: begin
          if (was_member) begin
            r.status = ST_PRESENT;
          end else if (ent >= SET_CAPACITY || size >= SET_CAPACITY) begin
            r.status = ST_RANGE;
          end else begin
            dense_ids[size] = ent;
            slot_of[ent]    = POS_W'(size);
            r.index         = POS_W'(size);
            size++;
          end
        end
        KIND_REMOVE: begin
          if (!was_member) begin
            r.status = ST_ABSENT;
          end else begin
            // The last dense entry fills the hole; when the hole is the last slot
            // this writes the entry back onto itself.
            hole            = 32'(slot_of[ent]);
            last            = dense_ids[size-1];
            r.index         = POS_W'(hole);
            dense_ids[hole] = last;
            if (last < SET_CAPACITY) slot_of[last] = POS_W'(hole);
            size--;
          end
        end
        KIND_LOOKUP: begin
          if (!was_member) r.status = ST_ABSENT;
          else r.index = slot_of[ent];
        end
        KIND_CLEAR: begin
          size = 0;
        end
        KIND_READ: begin
          if (pos >= size || pos >= SET_CAPACITY) r.status = ST_RANGE;
          else r.entity_out = dense_ids[pos];
        end
        default: begin
        end
      endcase
      r.count   = COUNT_W'(size);
      answers_q = {answers_q, r};
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic found,
                               logic [POS_W-1:0] index, logic [ENT_W-1:0] entity_out,
                               logic [COUNT_W-1:0] count);
      set_result_t exp;
      if (answers_q.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d", status, count);
        errors++;
        return;
      end
      exp = answers_q.pop_front();
      check_field("status", exp.status, status);
      check_field("found", exp.found, found);
      check_field("index", exp.index, index);
      check_field("entity_out", exp.entity_out, entity_out);
      check_field("count", exp.count, count);
    endfunction

    function int outstanding();
      return answers_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [ENT_W-1:0]    in_entity;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [POS_W-1:0]    out_index;
  logic [ENT_W-1:0]    out_entity_out;
  logic [COUNT_W-1:0]  out_count;

  set_scoreboard sb;

  // Set while both sides should run without any idle cycle.
  bit steady;
  // Number of results taken so far; the receiver uses it to time its long hold-off.
  int results_seen;

  logic [ENT_W-1:0] id_pool [POOL_SIZE];

  sparse_set_membership_table #(
    .MAX_ENTITIES(SET_CAPACITY)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_entity     (in_entity),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_index     (out_index),
    .out_entity_out(out_entity_out),
    .out_count     (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Most identifiers come from a small pool so that inserts, removes and lookups
  // keep hitting members; the rest span the whole identifier range.
  function automatic logic [ENT_W-1:0] pick_entity();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE-1)];
    return ENT_W'($urandom_range(0, ENTITY_SPACE-1));
  endfunction

  // Offers one request after an optional gap and returns once it has been taken.
  // Inputs only change at the falling edge; the handshake is judged at the rising edge.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ENT_W-1:0] ent,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_kind     = kind;
    in_entity   = ent;
    in_position = pos;
    do @(posedge clk); while (!in_ready);
  endtask

  // A request with a random operation. Spare codes and out-of-range reads act as noise.
  task automatic send_mixed();
    int               r;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    r = $urandom_range(0, 99);
    if (r < 35) kind = KIND_INSERT;
    else if (r < 55) kind = KIND_REMOVE;
    else if (r < 73) kind = KIND_LOOKUP;
    else if (r < 90) kind = KIND_READ;
    else if (r < 93) kind = KIND_CLEAR;
    else if (r < 95) kind = KIND_SPARE_A;
    else if (r < 97) kind = KIND_SPARE_B;
    else kind = KIND_SPARE_C;
    if (kind == KIND_READ && $urandom_range(0, 99) < 80) pos = POS_W'($urandom_range(0, 79));
    else pos = POS_W'($urandom_range(0, ENTITY_SPACE-1));
    send_request(kind, pick_entity(), pos);
  endtask

  // Both channels are sampled at the rising edge; a request is noted before any
  // result at the same edge, though the latency keeps the two apart anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_kind, in_entity, in_position);
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_found, out_index, out_entity_out, out_count);
        results_seen++;
      end
    end
  end

  // Result side. Ready drops at random; once, after a few dozen results, it stays low
  // for a long stretch while the sender keeps offering, so the block backs up and
  // lowers in_ready.
  initial begin
    int idle_left;
    bit held;
    idle_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 30) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (idle_left > 0) begin
        out_ready = 1'b0;
        idle_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
    end
  end

  // Ends the run when neither channel has moved a request or result for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int               order [ENTITY_SPACE];
    int               j;
    int               tmp;
    logic [ENT_W-1:0] ent;

    sb           = new();
    steady       = 1'b0;
    results_seen = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_INSERT;
    in_entity    = '0;
    in_position  = '0;
    foreach (id_pool[i]) id_pool[i] = ENT_W'($urandom_range(0, ENTITY_SPACE-1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: an empty set, both ends of the identifier range, a duplicate
    // insert, a remove that moves the last entry into a hole, a remove of the last
    // entry itself, reads in and out of range, spare codes and a clear that leaves
    // stale map entries behind.
    send_request(KIND_LOOKUP, 10'd0, 10'd0);
    send_request(KIND_REMOVE, 10'd1023, 10'd1023);
    send_request(KIND_READ, 10'd0, 10'd0);
    send_request(KIND_INSERT, 10'd0, 10'd1023);
    send_request(KIND_INSERT, 10'd1023, 10'd0);
    send_request(KIND_INSERT, 10'd0, 10'd0);
    send_request(KIND_LOOKUP, 10'd1023, 10'd0);
    send_request(KIND_READ, 10'd0, 10'd1);
    send_request(KIND_READ, 10'd0, 10'd1023);
    send_request(KIND_INSERT, 10'h155, 10'h2aa);
    send_request(KIND_INSERT, 10'h2aa, 10'h155);
    send_request(KIND_REMOVE, 10'd0, 10'd0);
    send_request(KIND_LOOKUP, 10'h2aa, 10'd0);
    send_request(KIND_REMOVE, 10'h155, 10'd0);
    send_request(KIND_SPARE_A, 10'h2aa, 10'd3);
    send_request(KIND_SPARE_B, 10'd0, 10'd0);
    send_request(KIND_SPARE_C, 10'd1023, 10'd1023);
    send_request(KIND_CLEAR, 10'd1023, 10'd0);
    send_request(KIND_LOOKUP, 10'd1023, 10'd0);
    send_request(KIND_INSERT, 10'd1023, 10'd0);
    send_request(KIND_READ, 10'd1023, 10'd0);
    send_request(KIND_REMOVE, 10'd1023, 10'd0);
    send_request(KIND_READ, 10'd0, 10'd0);

    // Random mix around a small pool of identifiers, with one stretch that runs
    // back to back on both sides.
    for (int n = 0; n < RANDOM_MIX_ITEMS; n++) begin
      steady = (n >= 100 && n < 150);
      send_mixed();
    end
    steady = 1'b0;

    // Fill about half of the set in a random order, with lookups and reads in
    // between, so that counts, positions and stored identifiers reach their upper bits.
    send_request(KIND_CLEAR, pick_entity(), POS_W'($urandom_range(0, ENTITY_SPACE-1)));
    for (int i = 0; i < ENTITY_SPACE; i++) order[i] = i;
    for (int i = ENTITY_SPACE - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < FILL_ITEMS; i++) begin
      send_request(KIND_INSERT, ENT_W'(order[i]), POS_W'($urandom_range(0, ENTITY_SPACE-1)));
      if ($urandom_range(0, 15) == 0) begin
        send_request(KIND_READ, pick_entity(), POS_W'($urandom_range(0, i + 1)));
        send_request(KIND_LOOKUP, ENT_W'(order[$urandom_range(0, ENTITY_SPACE-1)]), '0);
      end
    end

    // With about half of the identifiers members, inserts, removes and lookups split
    // between hits and misses; each remove is followed by an out-of-range read and a re-insert.
    send_request(KIND_READ, pick_entity(), 10'd1023);
    for (int n = 0; n < 32; n++) begin
      ent = ENT_W'($urandom_range(0, ENTITY_SPACE-1));
      case ($urandom_range(0, 3))
        0: send_request(KIND_READ, ent, POS_W'($urandom_range(0, ENTITY_SPACE-1)));
        1: send_request(KIND_LOOKUP, ent, POS_W'($urandom_range(0, ENTITY_SPACE-1)));
        2: send_request(KIND_INSERT, ent, POS_W'($urandom_range(0, ENTITY_SPACE-1)));
        default: begin
          send_request(KIND_REMOVE, ent, POS_W'($urandom_range(0, ENTITY_SPACE-1)));
          send_request(KIND_READ, ent, 10'd1023);
          send_request(KIND_INSERT, ent, POS_W'($urandom_range(0, ENTITY_SPACE-1)));
        end
      endcase
    end
    send_request(KIND_CLEAR, pick_entity(), '0);

    @(negedge clk);
    in_valid = 1'b0;

    // Wait for every expected result, then a little longer to catch stray ones.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
